[src/lav_pkg.sv]
package lav_pkg;

  // Words that ride alongside a vector through the normalizer.
  // Slots 0..2 always hold the eye point; slots 3..5 hold up or back.
  typedef logic [5:0][31:0] side_t;

  localparam int SIDE_EYE = 0;
  localparam int SIDE_AUX = 3;

  // Round half away from zero by 30 bits and saturate to 32-bit signed.
  function automatic logic [31:0] rnd_sat(input logic signed [65:0] v);
    logic [65:0] mag;
    logic [35:0] r;
    logic [31:0] res;
    mag = v[65] ? 66'(-v) : 66'(v);
    r = 36'((mag + 66'd536870912) >> 30);
    if (v[65]) begin
      res = (r > 36'h080000000) ? 32'h80000000 : 32'(36'd0 - r);
    end else begin
      res = (r > 36'h07FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
    end
    return res;
  endfunction

endpackage

[src/lav_nrm.sv]
module lav_nrm import lav_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0][63:0] vec,
  input  side_t            in_side,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0][31:0] res,
  output side_t            out_side
);

  localparam int ST_MAG = 0;
  localparam int ST_GRP = 1;
  localparam int ST_AMT = 2;
  localparam int ST_SHF = 3;
  localparam int ST_SQR = 4;
  localparam int ST_SUM = 5;
  localparam int ST_RT0 = 6;
  localparam int RT = 16;
  localparam int ST_NUM = ST_RT0 + RT;
  localparam int ST_DV0 = ST_NUM + 1;
  localparam int DV = 8;
  localparam int ST_OUT = ST_DV0 + DV;
  localparam int NS = ST_OUT + 1;

  logic [NS-1:0] vld;
  logic [NS:0]   load;

  assign load[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_load
    assign load[k] = !vld[k] || load[k+1];
  end
  assign in_ready  = load[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (load[k]) vld[k] <= vld[k-1];
      end
    end
  end

  side_t      side_p [NS];
  logic [2:0] sgn_p  [ST_OUT];
  logic       zro_p  [ST_OUT];

  // Magnitudes, signs and the largest magnitude.
  logic [2:0][63:0] amag;
  logic [62:0]      mx01, mx_c;
  logic [2:0]       neg_c;
  logic [2:0][62:0] mag0, mag1, mag2;
  logic [62:0]      mx0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_c[i] = vec[i][63];
      amag[i]  = vec[i][63] ? (64'd0 - vec[i]) : vec[i];
    end
    mx01 = (amag[0][62:0] > amag[1][62:0]) ? amag[0][62:0] : amag[1][62:0];
    mx_c = (amag[2][62:0] > mx01) ? amag[2][62:0] : mx01;
  end

  always_ff @(posedge clk) begin
    if (load[ST_MAG]) begin
      for (int i = 0; i < 3; i++) mag0[i] <= amag[i][62:0];
      mx0         <= mx_c;
      sgn_p[0]    <= neg_c;
      zro_p[0]    <= (vec[0] == 64'd0) && (vec[1] == 64'd0) && (vec[2] == 64'd0);
      side_p[0]   <= in_side;
    end
    for (int k = 1; k < NS; k++) begin
      if (load[k]) side_p[k] <= side_p[k-1];
    end
    for (int k = 1; k < ST_OUT; k++) begin
      if (load[k]) begin
        sgn_p[k] <= sgn_p[k-1];
        zro_p[k] <= zro_p[k-1];
      end
    end
  end

  // Leading-one search, split into byte groups and then the top group.
  logic [63:0]      wide;
  logic [7:0]       nz_c, grp_nz;
  logic [7:0][2:0]  pos_c, grp_pos;

  always_comb begin
    wide = {1'b0, mx0};
    for (int g = 0; g < 8; g++) begin
      nz_c[g]  = |wide[8*g +: 8];
      pos_c[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (wide[8*g + b]) pos_c[g] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[ST_GRP]) begin
      grp_nz  <= nz_c;
      grp_pos <= pos_c;
      mag1    <= mag0;
    end
  end

  logic [6:0] bl;
  logic [5:0] dn_c, dn;
  logic [4:0] up_c, up;

  always_comb begin
    bl = 7'd0;
    for (int g = 0; g < 8; g++) begin
      if (grp_nz[g]) bl = 7'(8*g + 1) + 7'(grp_pos[g]);
    end
    dn_c = (bl > 7'd31) ? 6'(bl - 7'd31) : 6'd0;
    up_c = (bl < 7'd31) ? 5'(7'd31 - bl) : 5'd0;
  end

  always_ff @(posedge clk) begin
    if (load[ST_AMT]) begin
      dn   <= dn_c;
      up   <= up_c;
      mag2 <= mag1;
    end
  end

  // Shift so that the largest magnitude lands in [2^30, 2^31).
  logic [2:0][62:0] sh_c;
  logic [2:0][30:0] msh_p [ST_SHF:ST_NUM-1];

  always_comb begin
    for (int i = 0; i < 3; i++) sh_c[i] = (mag2[i] >> dn) << up;
  end

  always_ff @(posedge clk) begin
    if (load[ST_SHF]) begin
      for (int i = 0; i < 3; i++) msh_p[ST_SHF][i] <= sh_c[i][30:0];
    end
    for (int k = ST_SHF + 1; k < ST_NUM; k++) begin
      if (load[k]) msh_p[k] <= msh_p[k-1];
    end
  end

  logic [2:0][61:0] sq;
  logic [63:0]      sum_q;

  always_ff @(posedge clk) begin
    if (load[ST_SQR]) begin
      for (int i = 0; i < 3; i++) sq[i] <= 62'(msh_p[ST_SHF][i]) * 62'(msh_p[ST_SHF][i]);
    end
    if (load[ST_SUM]) begin
      sum_q <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
    end
  end

  // Integer square root, two result bits per stage.
  logic [65:0] rt_rem  [RT];
  logic [31:0] rt_root [RT];

  for (genvar k = 0; k < RT; k++) begin : g_rt
    logic [65:0] rem_i, rem_o, t;
    logic [31:0] root_i, root_o;
    if (k == 0) begin : g_first
      assign rem_i  = {2'b00, sum_q};
      assign root_i = '0;
    end else begin : g_next
      assign rem_i  = rt_rem[k-1];
      assign root_i = rt_root[k-1];
    end
    always_comb begin
      rem_o  = rem_i;
      root_o = root_i;
      t      = '0;
      for (int b = 0; b < 2; b++) begin
        t = (66'(root_o) << (32 - 2*k - b)) + (66'd1 << (62 - 4*k - 2*b));
        if (rem_o >= t) begin
          rem_o  = rem_o - t;
          root_o = root_o | (32'd1 << (31 - 2*k - b));
        end
      end
    end
    always_ff @(posedge clk) begin
      if (load[ST_RT0 + k]) begin
        rt_rem[k]  <= rem_o;
        rt_root[k] <= root_o;
      end
    end
  end

  // Dividend m * 2^30 + floor(L/2).
  logic [2:0][61:0] num_q;
  logic [31:0]      len_q;

  always_ff @(posedge clk) begin
    if (load[ST_NUM]) begin
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= {1'b0, msh_p[ST_NUM-1][i], 30'd0} + {31'd0, rt_root[RT-1][31:1]};
      end
      len_q <= rt_root[RT-1];
    end
  end

  // Restoring division, four quotient bits per stage and three lanes.
  logic [2:0][32:0] dv_rem [DV];
  logic [2:0][30:0] dv_q   [DV];
  logic [2:0][61:0] dv_num [DV];
  logic [31:0]      dv_len [DV];

  for (genvar d = 0; d < DV; d++) begin : g_dv
    logic [2:0][32:0] rem_i, rem_o;
    logic [2:0][30:0] q_i, q_o;
    logic [2:0][61:0] num_i;
    logic [31:0]      len_i;
    if (d == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_i[i] = {2'b00, num_q[i][61:31]};
      end
      assign q_i   = '0;
      assign num_i = num_q;
      assign len_i = len_q;
    end else begin : g_next
      assign rem_i = dv_rem[d-1];
      assign q_i   = dv_q[d-1];
      assign num_i = dv_num[d-1];
      assign len_i = dv_len[d-1];
    end
    always_comb begin
      int j;
      rem_o = rem_i;
      q_o   = q_i;
      for (int i = 0; i < 3; i++) begin
        for (int b = 0; b < 4; b++) begin
          j = 30 - 4*d - b;
          if (j >= 0) begin
            rem_o[i] = {rem_o[i][31:0], num_i[i][6'(j)]};
            if (rem_o[i] >= {1'b0, len_i}) begin
              rem_o[i] = rem_o[i] - {1'b0, len_i};
              q_o[i]   = q_o[i] | (31'd1 << j);
            end
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (load[ST_DV0 + d]) begin
        dv_rem[d] <= rem_o;
        dv_q[d]   <= q_o;
        dv_num[d] <= num_i;
        dv_len[d] <= len_i;
      end
    end
  end

  logic [2:0][31:0] res_q;

  always_ff @(posedge clk) begin
    if (load[ST_OUT]) begin
      for (int i = 0; i < 3; i++) begin
        if (zro_p[ST_OUT-1]) begin
          res_q[i] <= 32'd0;
        end else if (sgn_p[ST_OUT-1][i]) begin
          res_q[i] <= 32'd0 - {1'b0, dv_q[DV-1][i]};
        end else begin
          res_q[i] <= {1'b0, dv_q[DV-1][i]};
        end
      end
    end
  end

  assign res      = res_q;
  assign out_side = side_p[NS-1];

endmodule

[src/look_at_view_matrix_core.sv]
// Look-at view matrix core: back, right and true-up axes plus translation terms.
// Throughput: one beat per cycle while out_stall is low; each normalizer is 32 register
// stages, set by its two-bit-per-stage square root and four-bit-per-stage divider.
// Reset clears all valid bits; payload registers are not reset.
module look_at_view_matrix_core import lav_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] up_x,
  input  logic signed [31:0] up_y,
  input  logic signed [31:0] up_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] right_x,
  output logic signed [31:0] right_y,
  output logic signed [31:0] right_z,
  output logic signed [31:0] true_up_x,
  output logic signed [31:0] true_up_y,
  output logic signed [31:0] true_up_z,
  output logic signed [31:0] back_x,
  output logic signed [31:0] back_y,
  output logic signed [31:0] back_z,
  output logic signed [31:0] shift_right,
  output logic signed [31:0] shift_up,
  output logic signed [31:0] shift_back
);

  logic v0, v1, v2, v3, v4, v5, v6, v7;
  logic load0, load1, load2, load3, load4, load5, load6, load7;
  logic n1_ready, n1_valid, n2_ready, n2_valid;

  assign load7 = !v7 || !out_stall;
  assign load6 = !v6 || load7;
  assign load5 = !v5 || load6;
  assign load4 = !v4 || load5;
  assign load3 = !v3 || load4;
  assign load2 = !v2 || n2_ready;
  assign load1 = !v1 || load2;
  assign load0 = !v0 || n1_ready;
  assign in_stall = !load0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else begin
      if (load0) v0 <= in_valid;
      if (load1) v1 <= n1_valid;
      if (load2) v2 <= v1;
      if (load3) v3 <= n2_valid;
      if (load4) v4 <= v3;
      if (load5) v5 <= v4;
      if (load6) v6 <= v5;
      if (load7) v7 <= v6;
    end
  end

  // Eye minus target.
  logic [2:0][63:0] vec0;
  side_t            side0;

  always_ff @(posedge clk) begin
    if (load0) begin
      vec0[0] <= 64'(eye_x) - 64'(target_x);
      vec0[1] <= 64'(eye_y) - 64'(target_y);
      vec0[2] <= 64'(eye_z) - 64'(target_z);
      side0   <= {up_z, up_y, up_x, eye_z, eye_y, eye_x};
    end
  end

  logic [2:0][31:0] n1_res;
  side_t            n1_side;

  lav_nrm u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v0),
    .in_ready (n1_ready),
    .vec      (vec0),
    .in_side  (side0),
    .out_valid(n1_valid),
    .out_ready(load1),
    .res      (n1_res),
    .out_side (n1_side)
  );

  // up x back
  logic signed [63:0] p1 [6];
  side_t              side1;

  always_ff @(posedge clk) begin
    if (load1) begin
      p1[0] <= $signed(n1_side[SIDE_AUX+1]) * $signed(n1_res[2]);
      p1[1] <= $signed(n1_side[SIDE_AUX+2]) * $signed(n1_res[1]);
      p1[2] <= $signed(n1_side[SIDE_AUX+2]) * $signed(n1_res[0]);
      p1[3] <= $signed(n1_side[SIDE_AUX])   * $signed(n1_res[2]);
      p1[4] <= $signed(n1_side[SIDE_AUX])   * $signed(n1_res[1]);
      p1[5] <= $signed(n1_side[SIDE_AUX+1]) * $signed(n1_res[0]);
      side1 <= {n1_res[2], n1_res[1], n1_res[0],
                n1_side[SIDE_EYE+2], n1_side[SIDE_EYE+1], n1_side[SIDE_EYE]};
    end
  end

  logic [2:0][63:0] vec2;
  side_t            side2;

  always_ff @(posedge clk) begin
    if (load2) begin
      vec2[0] <= p1[0] - p1[1];
      vec2[1] <= p1[2] - p1[3];
      vec2[2] <= p1[4] - p1[5];
      side2   <= side1;
    end
  end

  logic [2:0][31:0] n2_res;
  side_t            n2_side;

  lav_nrm u_right (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v2),
    .in_ready (n2_ready),
    .vec      (vec2),
    .in_side  (side2),
    .out_valid(n2_valid),
    .out_ready(load3),
    .res      (n2_res),
    .out_side (n2_side)
  );

  // Products for back x right and for the right and back dot products.
  logic signed [63:0] pb [6];
  logic signed [63:0] pr [3];
  logic signed [63:0] pk [3];
  logic [2:0][31:0]   r3, b3, e3;

  always_ff @(posedge clk) begin
    if (load3) begin
      pb[0] <= $signed(n2_side[SIDE_AUX+1]) * $signed(n2_res[2]);
      pb[1] <= $signed(n2_side[SIDE_AUX+2]) * $signed(n2_res[1]);
      pb[2] <= $signed(n2_side[SIDE_AUX+2]) * $signed(n2_res[0]);
      pb[3] <= $signed(n2_side[SIDE_AUX])   * $signed(n2_res[2]);
      pb[4] <= $signed(n2_side[SIDE_AUX])   * $signed(n2_res[1]);
      pb[5] <= $signed(n2_side[SIDE_AUX+1]) * $signed(n2_res[0]);
      for (int i = 0; i < 3; i++) begin
        pr[i] <= $signed(n2_res[i]) * $signed(n2_side[SIDE_EYE+i]);
        pk[i] <= $signed(n2_side[SIDE_AUX+i]) * $signed(n2_side[SIDE_EYE+i]);
        r3[i] <= n2_res[i];
        b3[i] <= n2_side[SIDE_AUX+i];
        e3[i] <= n2_side[SIDE_EYE+i];
      end
    end
  end

  logic signed [65:0] td [3];
  logic [2:0][31:0]   tup4, r4, b4, e4;
  logic signed [65:0] sr4, sk4;

  always_comb begin
    td[0] = 66'(pb[0]) - 66'(pb[1]);
    td[1] = 66'(pb[2]) - 66'(pb[3]);
    td[2] = 66'(pb[4]) - 66'(pb[5]);
  end

  always_ff @(posedge clk) begin
    if (load4) begin
      for (int i = 0; i < 3; i++) tup4[i] <= rnd_sat(td[i]);
      sr4 <= 66'(pr[0]) + 66'(pr[1]) + 66'(pr[2]);
      sk4 <= 66'(pk[0]) + 66'(pk[1]) + 66'(pk[2]);
      r4  <= r3;
      b4  <= b3;
      e4  <= e3;
    end
  end

  logic signed [63:0] pt [3];
  logic [2:0][31:0]   tup5, r5, b5;
  logic signed [65:0] sr5, sk5;

  always_ff @(posedge clk) begin
    if (load5) begin
      for (int i = 0; i < 3; i++) pt[i] <= $signed(tup4[i]) * $signed(e4[i]);
      tup5 <= tup4;
      r5   <= r4;
      b5   <= b4;
      sr5  <= sr4;
      sk5  <= sk4;
    end
  end

  logic [2:0][31:0]   tup6, r6, b6;
  logic signed [65:0] sr6, sk6, st6;

  always_ff @(posedge clk) begin
    if (load6) begin
      st6  <= 66'(pt[0]) + 66'(pt[1]) + 66'(pt[2]);
      tup6 <= tup5;
      r6   <= r5;
      b6   <= b5;
      sr6  <= sr5;
      sk6  <= sk5;
    end
  end

  // Output register: translation terms are negated, rounded and saturated here.
  logic [2:0][31:0] tup7, r7, b7;
  logic [31:0]      shr7, shu7, shb7;

  always_ff @(posedge clk) begin
    if (load7) begin
      tup7 <= tup6;
      r7   <= r6;
      b7   <= b6;
      shr7 <= rnd_sat(-sr6);
      shu7 <= rnd_sat(-st6);
      shb7 <= rnd_sat(-sk6);
    end
  end

  assign out_valid   = v7;
  assign right_x     = r7[0];
  assign right_y     = r7[1];
  assign right_z     = r7[2];
  assign true_up_x   = tup7[0];
  assign true_up_y   = tup7[1];
  assign true_up_z   = tup7[2];
  assign back_x      = b7[0];
  assign back_y      = b7[1];
  assign back_z      = b7[2];
  assign shift_right = shr7;
  assign shift_up    = shu7;
  assign shift_back  = shb7;

`ifndef NO_ASSERTIONS
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

  a_back_unit_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (back_x <= 32'sd1073741824 && back_x >= -32'sd1073741824 &&
                   back_y <= 32'sd1073741824 && back_y >= -32'sd1073741824 &&
                   back_z <= 32'sd1073741824 && back_z >= -32'sd1073741824))
    else $error("back axis component exceeds one");

  a_zero_right: assert property (@(posedge clk) disable iff (rst)
    (out_valid && right_x == 32'sd0 && right_y == 32'sd0 && right_z == 32'sd0) |->
    (shift_right == 32'sd0 && true_up_x == 32'sd0 && true_up_y == 32'sd0 &&
     true_up_z == 32'sd0 && shift_up == 32'sd0))
    else $error("zero right axis with nonzero dependent terms");
`endif

endmodule

[sim/tb_look_at_view_matrix_core.sv]
module tb_look_at_view_matrix_core;
  import lav_pkg::*;

  localparam int PIPE_DEPTH = 72;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [8:0][31:0] pose_t;
  typedef logic [11:0][31:0] view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic signed [31:0] up_x = '0, up_y = '0, up_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] right_x, right_y, right_z;
  logic signed [31:0] true_up_x, true_up_y, true_up_z;
  logic signed [31:0] back_x, back_y, back_z;
  logic signed [31:0] shift_right, shift_up, shift_back;

  view_t pending_views[$];
  int mismatches = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  look_at_view_matrix_core dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint unsigned sqrt_floor(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Scales an exact vector to a Q2.30 unit vector; a zero vector stays zero.
  function automatic void unit_vec(input longint v0, v1, v2,
                                   output longint o0, o1, o2);
    longint unsigned m[3];
    longint vv[3];
    longint unsigned mx, sum, len, q;
    int up_sh, down_sh;
    vv[0] = v0; vv[1] = v1; vv[2] = v2;
    mx = 0; sum = 0; up_sh = 0; down_sh = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = vv[i] < 0 ? -vv[i] : vv[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      o0 = 0; o1 = 0; o2 = 0;
      return;
    end
    while ((mx >> down_sh) >= (64'd1 << 31)) down_sh++;
    while ((mx << up_sh) < (64'd1 << 30)) up_sh++;
    for (int i = 0; i < 3; i++) begin
      m[i] = (m[i] >> down_sh) << up_sh;
      sum += m[i] * m[i];
    end
    len = sqrt_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * (64'd1 << 30) + (len >> 1)) / len;
      vv[i] = vv[i] < 0 ? -longint'(q) : longint'(q);
    end
    o0 = vv[0]; o1 = vv[1]; o2 = vv[2];
  endfunction

  function automatic longint round_q30_sat(input longint v);
    longint unsigned mag, r;
    mag = v < 0 ? -v : v;
    r = (mag + (64'd1 << 29)) >> 30;
    if (v < 0) return r > (64'd1 << 31) ? -longint'(64'h80000000) : -longint'(r);
    return r > 64'h7FFFFFFF ? longint'(64'h7FFFFFFF) : longint'(r);
  endfunction

  function automatic view_t predict_view(input pose_t p);
    longint e[3], t[3], u[3], bk[3], rt[3], tu[3], c[3];
    view_t v;
    for (int i = 0; i < 3; i++) begin
      e[i] = longint'($signed(p[i]));
      t[i] = longint'($signed(p[3 + i]));
      u[i] = longint'($signed(p[6 + i]));
    end
    unit_vec(e[0] - t[0], e[1] - t[1], e[2] - t[2], bk[0], bk[1], bk[2]);
    c[0] = u[1] * bk[2] - u[2] * bk[1];
    c[1] = u[2] * bk[0] - u[0] * bk[2];
    c[2] = u[0] * bk[1] - u[1] * bk[0];
    unit_vec(c[0], c[1], c[2], rt[0], rt[1], rt[2]);
    tu[0] = round_q30_sat(bk[1] * rt[2] - bk[2] * rt[1]);
    tu[1] = round_q30_sat(bk[2] * rt[0] - bk[0] * rt[2]);
    tu[2] = round_q30_sat(bk[0] * rt[1] - bk[1] * rt[0]);
    for (int i = 0; i < 3; i++) begin
      v[i] = rt[i][31:0];
      v[3 + i] = tu[i][31:0];
      v[6 + i] = bk[i][31:0];
    end
    v[9] = 32'(round_q30_sat(-(rt[0] * e[0] + rt[1] * e[1] + rt[2] * e[2])));
    v[10] = 32'(round_q30_sat(-(tu[0] * e[0] + tu[1] * e[1] + tu[2] * e[2])));
    v[11] = 32'(round_q30_sat(-(bk[0] * e[0] + bk[1] * e[1] + bk[2] * e[2])));
    return v;
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // Holds valid high across back-to-back beats; it is only lowered for a gap.
  task automatic send_pose(input pose_t p);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    eye_x <= p[0]; eye_y <= p[1]; eye_z <= p[2];
    target_x <= p[3]; target_y <= p[4]; target_z <= p[5];
    up_x <= p[6]; up_y <= p[7]; up_z <= p[8];
    do @(posedge clk); while (in_stall);
    pending_views.push_back(predict_view(p));
  endtask

  function automatic pose_t make_pose(input logic [31:0] ex, ey, ez, tx, ty, tz,
                                      ux, uy, uz);
    return {uz, uy, ux, tz, ty, tx, ez, ey, ex};
  endfunction

  always @(posedge clk) begin
    view_t got, want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {shift_back, shift_up, shift_right, back_z, back_y, back_x,
               true_up_z, true_up_y, true_up_x, right_z, right_y, right_x};
        if (pending_views.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat");
        end else begin
          want = pending_views.pop_front();
          for (int i = 0; i < 12; i++) begin
            if (got[i] !== want[i]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("field %0d: expected %h, got %h", i, want[i], got[i]);
            end
          end
        end
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_extremes();
    send_pose(make_pose(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                        32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                        32'h80000000, 32'h7FFFFFFF, 32'h80000000));
    send_pose(make_pose(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        32'h7FFFFFFF, 32'h80000000, 32'h00000000));
    send_pose(make_pose(32'h00000001, 32'h00000000, 32'h00000000,
                        32'h00000000, 32'h00000000, 32'h00000000,
                        32'h00000000, 32'h00000001, 32'h00000000));
    send_pose(make_pose(32'h00050000, 32'h00030000, 32'h00080000,
                        32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0));
    send_pose(make_pose(32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF,
                        32'h00000001, 32'hFFFFFFFF, 32'h00000001,
                        32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000001));
  endtask

  task automatic test_degenerate();
    // Eye on the target, then up zero, then up along the view direction.
    send_pose(make_pose(32'h00012345, 32'hFFF00000, 32'h7FFFFFFF,
                        32'h00012345, 32'hFFF00000, 32'h7FFFFFFF,
                        32'h0, 32'h00010000, 32'h0));
    send_pose(make_pose(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h80000000,
                        32'h0, 32'h0, 32'h0));
    send_pose(make_pose(32'h00010000, 32'h00020000, 32'h00030000,
                        32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_pose(make_pose(32'h00010000, 32'h00020000, 32'h00030000,
                        32'h0, 32'h0, 32'h0,
                        32'hFFFE0000, 32'hFFFC0000, 32'hFFFA0000));
    send_pose(make_pose(32'h0, 32'h00000000, 32'h00100000,
                        32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000));
  endtask

  task automatic test_translation_saturation();
    send_pose(make_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0));
    send_pose(make_pose(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0));
    send_pose(make_pose(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                        32'h7FFFFFFE, 32'h80000001, 32'h7FFFFFFE,
                        32'h00010000, 32'h00010000, 32'hFFFF0000));
    send_pose(make_pose(32'h7FFF0000, 32'h0, 32'h0,
                        32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0));
  endtask

  function automatic logic [31:0] near_coord();
    return 32'($signed($urandom_range(0, 32'h00400000)) - 32'sh00200000);
  endfunction

  task automatic test_random_poses(input int count);
    pose_t p;
    int mode;
    logic [31:0] k;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) p[i] = $urandom();
      if (mode < 5) begin
        for (int i = 0; i < 9; i++) p[i] = near_coord();
      end else if (mode == 5) begin
        for (int i = 0; i < 3; i++) p[3 + i] = p[i];
      end else if (mode == 6) begin
        for (int i = 0; i < 3; i++) begin
          p[i] = 32'($signed($urandom_range(0, 2000)) - 1000);
          p[3 + i] = 32'($signed($urandom_range(0, 2000)) - 1000);
        end
        k = 32'($signed($urandom_range(0, 200)) - 100);
        for (int i = 0; i < 3; i++) p[6 + i] = 32'($signed(p[i] - p[3 + i]) * $signed(k));
      end
      send_pose(p);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_degenerate();
    test_translation_saturation();
    test_random_poses(400);
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
